[design/obu_stream_framing_scanner_assert.svh]
// Assertion macros for the OBU framing scanner.
// Each macro has a checking form and an empty form for synthesis.
`ifndef OBU_STREAM_FRAMING_SCANNER_ASSERT_SVH
`define OBU_STREAM_FRAMING_SCANNER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define OBU_SFS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("obu framing scanner: assertion failed");

// Next-cycle implication.
`define OBU_SFS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("obu framing scanner: assertion failed");

`else

`define OBU_SFS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define OBU_SFS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[design/obu_sfs_pkg.sv]
package obu_sfs_pkg;

    // Field widths fixed by the stream format
    localparam int TYPE_W      = 4;
    localparam int TALLY_DEPTH = 1 << TYPE_W;
    localparam int CNT_W       = 32;
    localparam int SIZE_W      = 64;
    localparam int OFS_OUT_W   = 32;

    // LEB128 limits and masks
    localparam logic [3:0] LEB_MAX_BYTES = 4'd10;
    localparam logic [7:0] LEB_VALUE_MASK = 8'h7F;
    localparam logic [TYPE_W-1:0] TYPE_SEQ_HDR = 4'd1;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_EXT     = 5'b00010,
        PH_SIZE    = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_PAD     = 5'b10000
    } phase_t;

    // Status codes reported in the summary
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FORBIDDEN = 3'd1,
        ST_NO_SIZE   = 3'd2,
        ST_TRUNC_EXT = 3'd3,
        ST_BAD_LEB   = 3'd4,
        ST_OVERRUN   = 3'd5
    } status_t;

    // Record kinds
    localparam logic KIND_UNIT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic              record_kind;
        logic [TYPE_W-1:0] unit_type;
        logic [31:0]       payload_start;
        logic [63:0]       payload_length;
        logic [31:0]       type_tally;
        logic [2:0]        status_code;
        logic [31:0]       unit_total;
        logic [31:0]       seqhdr_total;
        logic [31:0]       seqhdr_offset;
        logic [63:0]       seqhdr_length;
        logic              final_flag;
    } out_item_t;

    // Request from the parser to the per-type tally memory
    typedef struct packed {
        logic              rd_en;
        logic [TYPE_W-1:0] rd_addr;
        logic              wr_en;
        logic [TYPE_W-1:0] wr_addr;
        logic [CNT_W-1:0]  wr_data;
        logic              clear;
    } tally_req_t;

endpackage

[design/obu_sfs_tally_mem.sv]
`include "obu_stream_framing_scanner_assert.svh"

module obu_sfs_tally_mem
    import obu_sfs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  tally_req_t       req,
    output logic [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0]       mem [TALLY_DEPTH];
    logic [TALLY_DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0]       rd_data_reg;

    // Per-entry valid bits; a cleared entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port, held until the next read
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

    `OBU_SFS_ASSERT_NXT(a_clear_empties, aclk, aresetn, req.clear, valid_reg == '0)

endmodule

[design/obu_sfs_parser.sv]
`include "obu_stream_framing_scanner_assert.svh"

module obu_sfs_parser
    import obu_sfs_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  in_item_t         item,
    output logic             res_valid,
    output out_item_t        result,
    output tally_req_t       tally_req,
    input  logic [CNT_W-1:0] tally_rd
);

    phase_t                 phase_reg, phase_next;
    status_t                err_reg, err_next;
    logic [TYPE_W-1:0]      type_reg, type_next;
    logic [SIZE_W-1:0]      acc_reg, acc_next;
    logic [3:0]             idx_reg, idx_next;
    logic [SIZE_W-1:0]      left_reg, left_next;
    logic [OFFSET_BITS-1:0] offs_reg, offs_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [CNT_W-1:0]       seq_cnt_reg, seq_cnt_next;
    logic [OFFSET_BITS-1:0] seq_off_reg, seq_off_next;
    logic [SIZE_W-1:0]      seq_len_reg, seq_len_next;

    logic [7:0]        b;
    logic              eos;
    logic              done;
    logic [6:0]        shamt_full;
    logic [SIZE_W-1:0] acc_new;
    logic [SIZE_W-1:0] left_dec;
    logic [3:0]        idx_inc;
    logic [CNT_W-1:0]  tally_new;

    assign b   = item.byte_value;
    assign eos = item.end_of_stream;

    // LEB128 accumulate and payload countdown datapath
    assign shamt_full = 7'(idx_reg) * 7'd7;
    assign acc_new    = acc_reg | (SIZE_W'(b & LEB_VALUE_MASK) << shamt_full[5:0]);
    assign left_dec   = left_reg - SIZE_W'(1);
    assign idx_inc    = idx_reg + 4'd1;
    assign tally_new  = tally_rd + CNT_W'(1);

    // Per-byte parse step
    always_comb begin
        phase_next   = phase_reg;
        err_next     = err_reg;
        type_next    = type_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        left_next    = left_reg;
        start_next   = start_reg;
        total_next   = total_reg;
        seq_cnt_next = seq_cnt_reg;
        seq_off_next = seq_off_reg;
        seq_len_next = seq_len_reg;
        offs_next    = offs_reg + OFFSET_BITS'(1);
        done         = 1'b0;
        tally_req    = '0;

        if (err_reg == ST_OK) begin
            unique case (phase_reg)
                PH_EXT: begin
                    phase_next = PH_SIZE;
                end
                PH_SIZE: begin
                    acc_next = acc_new;
                    idx_next = idx_inc;
                    if (!b[7]) begin
                        start_next = offs_next;
                        if (acc_new == '0) begin
                            done       = 1'b1;
                            phase_next = PH_HEADER;
                        end else begin
                            left_next  = acc_new;
                            phase_next = PH_PAYLOAD;
                        end
                    end else if (idx_inc >= LEB_MAX_BYTES) begin
                        err_next = ST_BAD_LEB;
                    end
                end
                PH_PAYLOAD: begin
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        done       = 1'b1;
                        phase_next = PH_HEADER;
                    end
                end
                PH_PAD: begin
                    if (b != 8'd0) begin
                        err_next = ST_NO_SIZE;
                    end
                end
                default: begin
                    // header byte; unknown phase codes land here too
                    if (b == 8'd0) begin
                        phase_next = PH_PAD;
                    end else if (b[7]) begin
                        err_next = ST_FORBIDDEN;
                    end else if (!b[1]) begin
                        err_next = ST_NO_SIZE;
                    end else begin
                        type_next         = b[6:3];
                        acc_next          = '0;
                        idx_next          = '0;
                        phase_next        = b[2] ? PH_EXT : PH_SIZE;
                        tally_req.rd_en   = accept;
                        tally_req.rd_addr = b[6:3];
                    end
                end
            endcase

            // stream ends inside a unit
            if (eos && err_next == ST_OK) begin
                if (phase_next == PH_EXT) begin
                    err_next = ST_TRUNC_EXT;
                end else if (phase_next == PH_SIZE) begin
                    err_next = ST_BAD_LEB;
                end else if (phase_next == PH_PAYLOAD) begin
                    err_next = ST_OVERRUN;
                end
            end
        end

        // unit completion: counters and tally write-back
        if (done) begin
            total_next = total_reg + CNT_W'(1);
            if (type_reg == TYPE_SEQ_HDR) begin
                if (seq_cnt_reg == '0) begin
                    seq_off_next = start_next;
                    seq_len_next = acc_next;
                end
                seq_cnt_next = seq_cnt_reg + CNT_W'(1);
            end
            tally_req.wr_en   = accept;
            tally_req.wr_addr = type_reg;
            tally_req.wr_data = tally_new;
        end
        tally_req.clear = accept && eos;
    end

    // Result item
    always_comb begin
        res_valid             = eos || done;
        result.record_kind    = eos ? KIND_SUMMARY : KIND_UNIT;
        result.unit_type      = done ? type_reg : '0;
        result.payload_start  = done ? OFS_OUT_W'(start_next) : '0;
        result.payload_length = done ? acc_next : '0;
        result.type_tally     = done ? tally_new : '0;
        result.status_code    = eos ? err_next : ST_OK;
        result.unit_total     = total_next;
        result.seqhdr_total   = seq_cnt_next;
        result.seqhdr_offset  = OFS_OUT_W'(seq_off_next);
        result.seqhdr_length  = seq_len_next;
        result.final_flag     = 1'b1;
    end

    // State registers; end of stream returns everything to reset
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && eos)) begin
            phase_reg   <= PH_HEADER;
            err_reg     <= ST_OK;
            type_reg    <= '0;
            acc_reg     <= '0;
            idx_reg     <= '0;
            left_reg    <= '0;
            offs_reg    <= '0;
            start_reg   <= '0;
            total_reg   <= '0;
            seq_cnt_reg <= '0;
            seq_off_reg <= '0;
            seq_len_reg <= '0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            err_reg     <= err_next;
            type_reg    <= type_next;
            acc_reg     <= acc_next;
            idx_reg     <= idx_next;
            left_reg    <= left_next;
            offs_reg    <= offs_next;
            start_reg   <= start_next;
            total_reg   <= total_next;
            seq_cnt_reg <= seq_cnt_next;
            seq_off_reg <= seq_off_next;
            seq_len_reg <= seq_len_next;
        end
    end

    `OBU_SFS_ASSERT_IMP(a_write_only_on_done, aclk, aresetn, tally_req.wr_en, accept && res_valid)
    `OBU_SFS_ASSERT_NXT(a_error_sticky, aclk, aresetn, (err_reg != ST_OK) && !(accept && eos), err_reg == $past(err_reg))
    `OBU_SFS_ASSERT_NXT(a_eos_resets, aclk, aresetn, accept && eos, (phase_reg == PH_HEADER) && (total_reg == '0))

endmodule

[design/obu_stream_framing_scanner.sv]
// OBU framing scanner for size-delimited byte streams.
//
// Input channel (s_valid/s_ready/s_data): one stream byte per request with an
// end-of-stream flag. Result channel (m_valid/m_ready/m_data): a unit record
// on each non-end byte that completes an OBU, and a summary record on the end byte.
// At most one result per input byte.
//
// Throughput: one byte per clock unless a stalled result holds s_ready low.
// The per-type tally lives in a 16-entry memory with a registered read; the
// read is issued on the header byte and the write-back happens on the
// completing byte, at least one byte later, so it never stalls the stream.
// A result is registered at the edge that accepts its byte and drives m_valid.
//
// Reset (aresetn low, synchronous) and every end-of-stream byte return the
// parser to the header phase and clear all counts; tally entries are cleared
// by resetting their valid bits, so no clearing pass is needed.
// When the receiver stalls, the result waits in the output register and
// s_ready drops until it is taken; s_ready stays high while it drains.
`include "obu_stream_framing_scanner_assert.svh"

module obu_stream_framing_scanner
    import obu_sfs_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic             s_acc;
    logic             res_valid;
    out_item_t        result;
    tally_req_t       tally_req;
    logic [CNT_W-1:0] tally_rd;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_acc   = s_valid && s_ready;

    obu_sfs_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_acc),
        .item      (s_data),
        .res_valid (res_valid),
        .result    (result),
        .tally_req (tally_req),
        .tally_rd  (tally_rd)
    );

    obu_sfs_tally_mem u_tally (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tally_req),
        .rd_data (tally_rd)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_acc && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && res_valid) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `OBU_SFS_ASSERT_NXT(a_result_registered, aclk, aresetn, s_acc && res_valid, m_valid_reg)

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import obu_sfs_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    obu_stream_framing_scanner dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Stimulus and expected results
    in_item_t   pending_requests[$];
    out_item_t  expected_records[$];
    logic [7:0] stream_bytes[$];

    // Scanner state mirror
    phase_t      scan_phase;
    logic [3:0]  hdr_type;
    logic [63:0] leb_value;
    logic [3:0]  leb_index;
    logic [63:0] bytes_owed;
    logic [31:0] byte_offset;
    logic [31:0] payload_ofs;
    logic [31:0] unit_count;
    logic [31:0] tally_by_type[16];
    logic [31:0] seqhdr_seen;
    logic [31:0] first_seqhdr_ofs;
    logic [63:0] first_seqhdr_len;
    status_t     sticky_status;

    // Run statistics
    int mismatch_count = 0;
    int stream_count   = 0;
    int requests_sent  = 0;
    int unit_records   = 0;
    int summary_by_status[8];

    task automatic clear_scan_state();
        scan_phase       = PH_HEADER;
        hdr_type         = '0;
        leb_value        = '0;
        leb_index        = '0;
        bytes_owed       = '0;
        byte_offset      = '0;
        payload_ofs      = '0;
        unit_count       = '0;
        seqhdr_seen      = '0;
        first_seqhdr_ofs = '0;
        first_seqhdr_len = '0;
        sticky_status    = ST_OK;
        for (int i = 0; i < 16; i++) tally_by_type[i] = '0;
    endtask

    // Count the finished OBU and latch the first sequence header
    task automatic finish_unit();
        unit_count++;
        tally_by_type[hdr_type]++;
        if (hdr_type == TYPE_SEQ_HDR) begin
            if (seqhdr_seen == 0) begin
                first_seqhdr_ofs = payload_ofs;
                first_seqhdr_len = leb_value;
            end
            seqhdr_seen++;
        end
        scan_phase = PH_HEADER;
    endtask

    // Advance the mirror by one accepted byte, queue any result it causes
    task automatic predict_byte(input in_item_t req);
        logic [7:0] b;
        logic       last;
        logic       done;
        out_item_t  rec;
        b    = req.byte_value;
        last = req.end_of_stream;
        done = 1'b0;
        if (sticky_status == ST_OK) begin
            case (scan_phase)
                PH_EXT: begin
                    scan_phase = PH_SIZE;
                end
                PH_SIZE: begin
                    leb_value = leb_value
                              | (64'(b & LEB_VALUE_MASK) << ((7 * leb_index) & 63));
                    leb_index++;
                    if (!b[7]) begin
                        payload_ofs = byte_offset + 32'd1;
                        if (leb_value == 0) begin
                            finish_unit();
                            done = 1'b1;
                        end else begin
                            bytes_owed = leb_value;
                            scan_phase = PH_PAYLOAD;
                        end
                    end else if (leb_index >= LEB_MAX_BYTES) begin
                        sticky_status = ST_BAD_LEB;
                    end
                end
                PH_PAYLOAD: begin
                    bytes_owed--;
                    if (bytes_owed == 0) begin
                        finish_unit();
                        done = 1'b1;
                    end
                end
                PH_PAD: begin
                    if (b != 0) sticky_status = ST_NO_SIZE;
                end
                default: begin
                    if (b == 0) begin
                        scan_phase = PH_PAD;
                    end else if (b[7]) begin
                        sticky_status = ST_FORBIDDEN;
                    end else if (!b[1]) begin
                        sticky_status = ST_NO_SIZE;
                    end else begin
                        hdr_type   = b[6:3];
                        leb_value  = '0;
                        leb_index  = '0;
                        scan_phase = b[2] ? PH_EXT : PH_SIZE;
                    end
                end
            endcase
            // end flag inside an unfinished unit
            if (last && sticky_status == ST_OK) begin
                case (scan_phase)
                    PH_EXT:     sticky_status = ST_TRUNC_EXT;
                    PH_SIZE:    sticky_status = ST_BAD_LEB;
                    PH_PAYLOAD: sticky_status = ST_OVERRUN;
                    default:    ;
                endcase
            end
        end
        byte_offset++;

        if (last || done) begin
            rec             = '0;
            rec.record_kind = last ? KIND_SUMMARY : KIND_UNIT;
            if (done) begin
                rec.unit_type      = hdr_type;
                rec.payload_start  = payload_ofs;
                rec.payload_length = leb_value;
                rec.type_tally     = tally_by_type[hdr_type];
            end
            rec.status_code   = last ? sticky_status : ST_OK;
            rec.unit_total    = unit_count;
            rec.seqhdr_total  = seqhdr_seen;
            rec.seqhdr_offset = first_seqhdr_ofs;
            rec.seqhdr_length = first_seqhdr_len;
            rec.final_flag    = 1'b1;
            expected_records.push_back(rec);
        end
        if (last) clear_scan_state();
    endtask

    // Stream building helpers
    task automatic commit_stream();
        in_item_t req;
        for (int i = 0; i < stream_bytes.size(); i++) begin
            req.byte_value    = stream_bytes[i];
            req.end_of_stream = (i == stream_bytes.size() - 1);
            pending_requests.push_back(req);
        end
        stream_bytes.delete();
        stream_count++;
    endtask

    function automatic void add_header(input logic [3:0] t, input logic ext);
        stream_bytes.push_back({1'b0, t, ext, 1'b1, 1'($urandom_range(0, 1))});
        if (ext) stream_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic add_leb(input logic [63:0] v, input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'((v >> (7 * i)) & 64'h7F);
            if (i < n - 1) b[7] = 1'b1;
            stream_bytes.push_back(b);
        end
    endtask

    function automatic logic [3:0] pick_type();
        return ($urandom_range(0, 2) == 0) ? TYPE_SEQ_HDR : 4'($urandom_range(0, 15));
    endfunction

    // Well-formed OBU, sometimes with a padded size field
    task automatic add_unit();
        logic [63:0] sz;
        int          n;
        sz = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 5);
        n  = 1;
        while (n < 10 && (sz >> (7 * n)) != 0) n++;
        if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, 2);
        if ($urandom_range(0, 15) == 0) n = 10;
        if (n > 10) n = 10;
        add_header(pick_type(), 1'($urandom_range(0, 1)));
        add_leb(sz, n);
        for (int i = 0; i < sz; i++) stream_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Size fields of up to ten bytes; returns 1 when the stream must end after it
    function automatic bit add_long_size(input int kind);
        int n;
        add_header(pick_type(), 1'($urandom_range(0, 1)));
        case (kind)
            0: begin
                // value bits past bit 63 dropped, size ends up zero
                for (int i = 0; i < 9; i++) stream_bytes.push_back(8'h80);
                stream_bytes.push_back(8'($urandom_range(0, 127)) & 8'h7E);
                return 1'b0;
            end
            1: begin
                // continuation still set on the tenth byte
                for (int i = 0; i < 10; i++)
                    stream_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
                return 1'b1;
            end
            default: begin
                // random size of two to ten bytes, stream likely ends inside the payload
                n = $urandom_range(2, 10);
                for (int i = 0; i < n; i++)
                    stream_bytes.push_back((i < n - 1 ? 8'h80 : 8'h00)
                                           | 8'($urandom_range(0, 127)));
                for (int i = $urandom_range(0, 4); i > 0; i--)
                    stream_bytes.push_back(8'($urandom_range(0, 255)));
                return 1'b1;
            end
        endcase
    endfunction

    // Sender: bursts of requests with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            clear_scan_state();
        end else begin
            if (s_valid && s_ready) begin
                predict_byte(s_data);
                requests_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    s_data  <= pending_requests.pop_front();
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: free-running windows, either always ready or a stall pattern
    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_pos   = 0;
    int          window_left   = 0;
    bit          free_running  = 1'b1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (window_left == 0) begin
                window_left   = $urandom_range(20, 80);
                free_running  = ($urandom_range(0, 3) == 0);
                stall_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
            end
            window_left--;
            pattern_pos = (pattern_pos + 1) % 16;
            m_ready <= free_running ? 1'b1 : stall_pattern[pattern_pos];
        end
    end

    // Result checking
    task automatic compare_field(input string label, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_data);
                mismatch_count++;
            end else begin
                want = expected_records.pop_front();
                compare_field("record_kind", want.record_kind, m_data.record_kind);
                compare_field("unit_type", want.unit_type, m_data.unit_type);
                compare_field("payload_start", want.payload_start, m_data.payload_start);
                compare_field("payload_length", want.payload_length, m_data.payload_length);
                compare_field("type_tally", want.type_tally, m_data.type_tally);
                compare_field("status_code", want.status_code, m_data.status_code);
                compare_field("unit_total", want.unit_total, m_data.unit_total);
                compare_field("seqhdr_total", want.seqhdr_total, m_data.seqhdr_total);
                compare_field("seqhdr_offset", want.seqhdr_offset, m_data.seqhdr_offset);
                compare_field("seqhdr_length", want.seqhdr_length, m_data.seqhdr_length);
                compare_field("final_flag", want.final_flag, m_data.final_flag);
            end
            if (m_data.record_kind == KIND_SUMMARY)
                summary_by_status[m_data.status_code]++;
            else
                unit_records++;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int  target;
        int  units;
        int  cut;
        int  tail;
        bit  ended;

        // zero-size sequence header completing on the end byte
        stream_bytes = '{8'h0A, 8'h00};
        commit_stream();
        // forbidden bit, later bytes ignored
        stream_bytes = '{8'hFF, 8'h12};
        commit_stream();
        // header without size field
        stream_bytes = '{8'h08};
        commit_stream();
        // end where the extension byte is due
        stream_bytes = '{8'h7E};
        commit_stream();
        // end inside the size field
        stream_bytes = '{8'h12, 8'h85};
        commit_stream();
        // end with payload still owed
        stream_bytes = '{8'h32, 8'h03, 8'hAA};
        commit_stream();
        // sequence header with extension, then trailing zeros
        stream_bytes = '{8'h0E, 8'h5A, 8'h02, 8'h11, 8'h22, 8'h00, 8'h00, 8'h00};
        commit_stream();
        // nonzero byte after padding
        stream_bytes = '{8'h00, 8'h01};
        commit_stream();

        target = pending_requests.size() + 1900;
        while (pending_requests.size() < target) begin
            if ($urandom_range(0, 11) == 0) begin
                // pure noise
                for (int i = $urandom_range(1, 8); i > 0; i--)
                    stream_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                units = $urandom_range(1, 6);
                ended = 1'b0;
                for (int u = 0; u < units && !ended; u++) begin
                    case ($urandom_range(0, 19))
                        16:      ended = add_long_size(0);
                        17:      ended = add_long_size(1);
                        18:      ended = add_long_size(2);
                        default: add_unit();
                    endcase
                end
                if (ended) begin
                    for (int i = $urandom_range(0, 3); i > 0; i--)
                        stream_bytes.push_back(8'($urandom_range(0, 255)));
                end else begin
                    tail = $urandom_range(0, 9);
                    if (tail == 4 || tail == 5 || tail == 8) begin
                        for (int i = $urandom_range(1, 3); i > 0; i--)
                            stream_bytes.push_back(8'h00);
                        if (tail == 8) stream_bytes.push_back(8'($urandom_range(1, 255)));
                    end else if (tail == 6) begin
                        cut = $urandom_range(1, stream_bytes.size());
                        while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
                    end else if (tail == 7) begin
                        cut = $urandom_range(0, stream_bytes.size() - 1);
                        stream_bytes[cut] = 8'($urandom_range(0, 255));
                    end else if (tail == 9) begin
                        stream_bytes.push_back(8'($urandom_range(1, 255)));
                    end
                end
            end
            commit_stream();
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid) @(posedge aclk);
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d streams, %0d byte requests, %0d unit records",
                 stream_count, requests_sent, unit_records);
        $display("summaries by status: ok %0d, forbidden %0d, no size %0d, ext %0d, leb %0d, overrun %0d",
                 summary_by_status[ST_OK], summary_by_status[ST_FORBIDDEN],
                 summary_by_status[ST_NO_SIZE], summary_by_status[ST_TRUNC_EXT],
                 summary_by_status[ST_BAD_LEB], summary_by_status[ST_OVERRUN]);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/obu_sfs_pkg.sv
design/obu_sfs_tally_mem.sv
design/obu_sfs_parser.sv
design/obu_stream_framing_scanner.sv
dv/testbench.sv
